@@ design/ghhp_pkg.sv @@
// ----------------------------------------------------------------------------
// ghhp_pkg
// Shared constants and helpers for the gated hue histogram peak finder.
// ----------------------------------------------------------------------------
package ghhp_pkg;

   // Pixel counters saturate here
   localparam int MAX_PIXELS = 65536;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

   // Histogram geometry
   localparam int HUE_BINS = 180;
   localparam int ADDR_W   = $clog2(HUE_BINS);

   // Field widths of the streams
   localparam int PIX_W     = 8;
   localparam int ACC_OUT_W = 17;
   localparam int REQ_W     = 3 * PIX_W;
   localparam int RSP_W     = 32;

   // Fallback: accepted < floor(total * PCT / DIV), DIV divisible by PCT
   localparam int FALLBACK_PCT   = 5;
   localparam int PCT_DIV        = 100;
   localparam int FALLBACK_RATIO = PCT_DIV / FALLBACK_PCT;
   localparam int CMP_W          = CNT_W + $clog2(FALLBACK_RATIO) + 1;
   localparam logic [PIX_W-1:0] FALLBACK_HUE = PIX_W'(157);

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VAL = CSR_IDX_W'(1);

   typedef logic [CNT_W-1:0] count_type;

   // Saturating increment
   function automatic count_type sat_inc(input count_type v);
      count_type r;
      if (v < CNT_W'(MAX_PIXELS)) begin
         r = v + CNT_W'(1);
      end else begin
         r = CNT_W'(MAX_PIXELS);
      end
      return r;
   endfunction

   // Low bits of a count as reported on the result stream
   function automatic logic [ACC_OUT_W-1:0] to_out_count(input count_type v);
      logic [CNT_W+ACC_OUT_W-1:0] wide;
      wide = {{ACC_OUT_W{1'b0}}, v};
      return wide[ACC_OUT_W-1:0];
   endfunction

endpackage

@@ design/gated_hue_histogram_peak.sv @@
// ----------------------------------------------------------------------------
// gated_hue_histogram_peak
// Gated 180-bin hue histogram over one region with a mode search at its end.
// ----------------------------------------------------------------------------
// Pixels of a region are taken one per cycle; each passing pixel does a
// read-modify-write of its bin in the histogram RAM through a two-stage
// pipeline with forwarding, so back-to-back pixels of the same hue are safe.
// After the pixel marked tlast the input stalls while the block drains the
// pipeline, scans all 180 bins through the single RAM read port (one bin per
// cycle) and loads the result register. Bins are cleared at once through
// per-bin valid flops when the result is loaded. The next region's pixels
// are accepted while the loaded result waits; the input stays stalled while
// a finished region waits for a full result register.
module gated_hue_histogram_peak (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [ghhp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ghhp_pkg::PIX_W-1:0]          csr_wdata,
   // pixels
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ghhp_pkg::REQ_W-1:0]          req_tdata,   // hue, saturation, brightness
   input  logic                                req_tlast,   // last_pixel
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ghhp_pkg::RSP_W-1:0]          rsp_tdata,   // hue_center, accepted_count, zero pad
   output logic                                rsp_tuser    // used_fallback
);

   localparam logic [1:0] ST_ACC    = 2'd0;
   localparam logic [1:0] ST_DRAIN  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   localparam int AW = ghhp_pkg::ADDR_W;
   localparam int PW = ghhp_pkg::PIX_W;
   localparam int CW = ghhp_pkg::CNT_W;

   // histogram RAM and per-bin valid flags
   logic [CW-1:0]                  hist_mem [ghhp_pkg::HUE_BINS];
   logic [ghhp_pkg::HUE_BINS-1:0]  hist_vld_ff, hist_vld_in;
   logic [CW-1:0]                  rdata_ff;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] min_sat_ff, min_val_ff;

   ghhp_pkg::count_type total_ff, total_in, acc_ff, acc_in;

   // update pipeline
   logic          upd_vld_ff, upd_vld_in;
   logic [AW-1:0] upd_addr_ff;
   logic          wb_vld_ff;
   logic [AW-1:0] wb_addr_ff;
   logic [CW-1:0] wb_data_ff;

   // scan
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   logic          scan_rd_ff, scan_rd_in;
   logic [AW-1:0] rd_idx_ff;
   logic [CW-1:0] best_ff, best_in;
   logic [AW-1:0] center_ff, center_in;

   // captured region result
   logic                  fb_ff, fb_in;
   ghhp_pkg::count_type   res_cnt_ff, res_cnt_in;

   // result register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [PW-1:0]         rsp_hue_ff;
   logic [ghhp_pkg::ACC_OUT_W-1:0] rsp_cnt_ff;
   logic                  rsp_fb_ff;

   logic          req_acc, pass, last_bin, load_rsp, scan_issue;
   logic [PW-1:0] px_hue, px_sat, px_val;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [CW-1:0] upd_base, upd_new, scan_data;
   ghhp_pkg::count_type total_nx, acc_nx;
   logic [ghhp_pkg::CMP_W-1:0] fb_lhs, fb_rhs;

   // input decode and gate
   assign px_hue  = req_tdata[PW-1:0];
   assign px_sat  = req_tdata[2*PW-1:PW];
   assign px_val  = req_tdata[3*PW-1:2*PW];
   assign req_tready = (state_ff == ST_ACC);
   assign req_acc = req_tvalid && req_tready;
   assign pass    = (px_hue < PW'(ghhp_pkg::HUE_BINS)) && (px_sat >= min_sat_ff) &&
                    (px_val >= min_val_ff);

   // counters and fallback test: accepted < floor(total/R) <=> R*(accepted+1) <= total
   assign total_nx = ghhp_pkg::sat_inc(total_ff);
   assign acc_nx   = pass ? ghhp_pkg::sat_inc(acc_ff) : acc_ff;
   assign fb_lhs   = (ghhp_pkg::CMP_W'(acc_nx) + ghhp_pkg::CMP_W'(1)) *
                     ghhp_pkg::CMP_W'(ghhp_pkg::FALLBACK_RATIO);
   assign fb_rhs   = ghhp_pkg::CMP_W'(total_nx);

   // read-modify-write with forwarding of the write that shares the read edge
   always_comb begin
      if (wb_vld_ff && (wb_addr_ff == upd_addr_ff)) begin
         upd_base = wb_data_ff;
      end else if (hist_vld_ff[upd_addr_ff]) begin
         upd_base = rdata_ff;
      end else begin
         upd_base = '0;
      end
      upd_new = ghhp_pkg::sat_inc(upd_base);
   end

   // scan data and RAM read port select
   assign scan_data  = hist_vld_ff[rd_idx_ff] ? rdata_ff : '0;
   assign last_bin   = scan_rd_ff && (rd_idx_ff == AW'(ghhp_pkg::HUE_BINS - 1));
   assign scan_issue = (state_ff == ST_SCAN) &&
                       (scan_idx_ff <= AW'(ghhp_pkg::HUE_BINS - 1)) && !scan_rd_last_issued();
   assign rd_addr    = (state_ff == ST_SCAN) ? scan_idx_ff : px_hue[AW-1:0];
   assign rd_en      = scan_issue || (req_acc && pass);
   assign load_rsp   = (state_ff == ST_RESULT) && (!rsp_vld_ff || rsp_tready);

   // the scan stops issuing once the last bin has been read
   function automatic logic scan_rd_last_issued();
      return scan_rd_ff && (rd_idx_ff == AW'(ghhp_pkg::HUE_BINS - 1));
   endfunction

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      acc_in      = acc_ff;
      fb_in       = fb_ff;
      res_cnt_in  = res_cnt_ff;
      upd_vld_in  = req_acc && pass;
      scan_idx_in = scan_idx_ff;
      scan_rd_in  = scan_issue;
      best_in     = best_ff;
      center_in   = center_ff;
      hist_vld_in = hist_vld_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      if (upd_vld_ff) begin
         hist_vld_in[upd_addr_ff] = 1'b1;
      end

      if (req_acc) begin
         total_in = total_nx;
         acc_in   = acc_nx;
         if (req_tlast) begin
            fb_in      = (fb_lhs <= fb_rhs);
            res_cnt_in = acc_nx;
            total_in   = '0;
            acc_in     = '0;
         end
      end

      if (scan_issue) begin
         scan_idx_in = scan_idx_ff + AW'(1);
      end

      // running maximum, lowest index wins ties
      if (scan_rd_ff) begin
         if ((rd_idx_ff == '0) || (scan_data > best_ff)) begin
            best_in   = scan_data;
            center_in = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_ACC: begin
            if (req_acc && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in    = ST_SCAN;
            scan_idx_in = '0;
         end
         ST_SCAN: begin
            if (last_bin) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (load_rsp) begin
               state_in    = ST_ACC;
               rsp_vld_in  = 1'b1;
               hist_vld_in = '0;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   // histogram RAM: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= hist_mem[rd_addr];
      end
      if (upd_vld_ff) begin
         hist_mem[upd_addr_ff] <= upd_new;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACC;
         min_sat_ff  <= '0;
         min_val_ff  <= '0;
         total_ff    <= '0;
         acc_ff      <= '0;
         hist_vld_ff <= '0;
         upd_vld_ff  <= 1'b0;
         wb_vld_ff   <= 1'b0;
         scan_rd_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         acc_ff      <= acc_in;
         hist_vld_ff <= hist_vld_in;
         upd_vld_ff  <= upd_vld_in;
         wb_vld_ff   <= upd_vld_ff;
         scan_rd_ff  <= scan_rd_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) begin
            case (csr_index)
               ghhp_pkg::CSR_MIN_SAT: min_sat_ff <= csr_wdata;
               ghhp_pkg::CSR_MIN_VAL: min_val_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      upd_addr_ff <= px_hue[AW-1:0];
      wb_addr_ff  <= upd_addr_ff;
      wb_data_ff  <= upd_new;
      rd_idx_ff   <= scan_idx_ff;
      scan_idx_ff <= scan_idx_in;
      best_ff     <= best_in;
      center_ff   <= center_in;
      fb_ff       <= fb_in;
      res_cnt_ff  <= res_cnt_in;
      if (load_rsp) begin
         rsp_hue_ff <= fb_ff ? ghhp_pkg::FALLBACK_HUE : PW'(center_ff);
         rsp_fb_ff  <= fb_ff;
         rsp_cnt_ff <= ghhp_pkg::to_out_count(res_cnt_ff);
      end
   end

   // result stream
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(ghhp_pkg::RSP_W - PW - ghhp_pkg::ACC_OUT_W)'(0), rsp_cnt_ff, rsp_hue_ff};
   assign rsp_tuser  = rsp_fb_ff;

endmodule

@@ design/ghhp_checker.sv @@
// ----------------------------------------------------------------------------
// ghhp_checker
// Port-level checks for the gated hue histogram peak finder.
// ----------------------------------------------------------------------------
module ghhp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_wr_en,
   input logic [ghhp_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ghhp_pkg::PIX_W-1:0]     csr_wdata,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [ghhp_pkg::REQ_W-1:0]     req_tdata,   // hue, saturation, brightness
   input logic                           req_tlast,   // last_pixel
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ghhp_pkg::RSP_W-1:0]     rsp_tdata,   // hue_center, accepted_count, zero pad
   input logic                           rsp_tuser    // used_fallback
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // the end of a region stalls the pixel input for the bin scan
   a_scan_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("pixel input not stalled after last pixel");

   // a fallback result carries the fallback hue
   a_fb_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == ghhp_pkg::FALLBACK_HUE)
      else $error("fallback result with wrong hue");

   // a peak result names a real bin
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] < ghhp_pkg::PIX_W'(ghhp_pkg::HUE_BINS))
      else $error("peak hue outside histogram");

endmodule

bind gated_hue_histogram_peak ghhp_checker u_ghhp_checker (.*);

@@ tb/gated_hue_histogram_peak_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_hue_histogram_peak_checker
// Watches the pixel, result and register ports of the hue peak finder, keeps
// its own gated hue histogram per region, predicts each region's peak and
// compares it field by field with the result stream.
// ----------------------------------------------------------------------------
module gated_hue_histogram_peak_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ghhp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ghhp_pkg::PIX_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ghhp_pkg::REQ_W-1:0]     req_tdata,   // hue, saturation, brightness
   input  logic                           req_tlast,   // last_pixel
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ghhp_pkg::RSP_W-1:0]     rsp_tdata,   // hue_center, accepted_count, zero pad
   input  logic                           rsp_tuser,   // used_fallback
   output int                             fail_count,
   output int                             open_count,
   output int                             result_count,
   output int                             fallback_count
);

   localparam int PIX_W     = ghhp_pkg::PIX_W;
   localparam int ACC_OUT_W = ghhp_pkg::ACC_OUT_W;
   localparam int PAD_W     = ghhp_pkg::RSP_W - PIX_W - ACC_OUT_W;

   typedef struct packed {
      logic [PIX_W-1:0]     hue_center;
      logic                 used_fallback;
      logic [ACC_OUT_W-1:0] accepted_count;
   } peak_result_type;

   // newest prediction at the front, oldest at the back
   peak_result_type expected_peaks[$];
   int unsigned  hue_bins[ghhp_pkg::HUE_BINS];
   int unsigned  region_accepted;
   int unsigned  region_total;
   logic [PIX_W-1:0] gate_sat;
   logic [PIX_W-1:0] gate_val;
   int fails;
   int results;
   int fallbacks;

   initial begin
      fails     = 0;
      results   = 0;
      fallbacks = 0;
   end

   function automatic void clear_region();
      foreach (hue_bins[b]) hue_bins[b] = 0;
      region_accepted = 0;
      region_total    = 0;
   endfunction

   // Peak of the finished region, or the fallback hue when too few passed
   function automatic peak_result_type predict_peak();
      peak_result_type r;
      int unsigned  best;
      int unsigned  cutoff;
      cutoff = region_total * ghhp_pkg::FALLBACK_PCT / ghhp_pkg::PCT_DIV;
      r.accepted_count = ACC_OUT_W'(region_accepted);
      if (region_accepted < cutoff) begin
         r.hue_center    = ghhp_pkg::FALLBACK_HUE;
         r.used_fallback = 1'b1;
      end else begin
         r.hue_center    = '0;
         r.used_fallback = 1'b0;
         best = hue_bins[0];
         // strict compare keeps the lowest bin on a tie
         for (int b = 1; b < ghhp_pkg::HUE_BINS; b++) begin
            if (hue_bins[b] > best) begin
               best         = hue_bins[b];
               r.hue_center = PIX_W'(b);
            end
         end
      end
      return r;
   endfunction

   // One pixel transaction: gate, count, and close the region on the last pixel
   function automatic void take_pixel(input logic [ghhp_pkg::REQ_W-1:0] data,
                                      input logic last);
      logic [PIX_W-1:0] hue;
      logic [PIX_W-1:0] sat;
      logic [PIX_W-1:0] bri;
      hue = data[PIX_W-1:0];
      sat = data[PIX_W +: PIX_W];
      bri = data[2*PIX_W +: PIX_W];
      if (region_total < ghhp_pkg::MAX_PIXELS) region_total++;
      if (hue < ghhp_pkg::HUE_BINS && sat >= gate_sat && bri >= gate_val) begin
         if (hue_bins[hue] < ghhp_pkg::MAX_PIXELS) hue_bins[hue]++;
         if (region_accepted < ghhp_pkg::MAX_PIXELS) region_accepted++;
      end
      if (last) begin
         expected_peaks.push_front(predict_peak());
         clear_region();
      end
   endfunction

   // Result transaction against the oldest predicted peak
   function automatic void check_result();
      peak_result_type want;
      logic [PIX_W-1:0]     got_hue;
      logic [ACC_OUT_W-1:0] got_acc;
      logic [PAD_W-1:0]     got_pad;
      got_hue = rsp_tdata[PIX_W-1:0];
      got_acc = rsp_tdata[PIX_W +: ACC_OUT_W];
      got_pad = rsp_tdata[ghhp_pkg::RSP_W-1 -: PAD_W];
      results++;
      if (expected_peaks.size() == 0) begin
         $error("result with no region waiting: hue_center %0d, accepted_count %0d",
                got_hue, got_acc);
         fails++;
         return;
      end
      want = expected_peaks.pop_back();
      if (want.used_fallback) fallbacks++;
      if (got_hue !== want.hue_center) begin
         $error("hue_center: expected %0d, actual %0d", want.hue_center, got_hue);
         fails++;
      end
      if (rsp_tuser !== want.used_fallback) begin
         $error("used_fallback: expected %0d, actual %0d", want.used_fallback, rsp_tuser);
         fails++;
      end
      if (got_acc !== want.accepted_count) begin
         $error("accepted_count: expected %0d, actual %0d", want.accepted_count, got_acc);
         fails++;
      end
      if (got_pad !== '0) begin
         $error("padding: expected 0, actual %0h", got_pad);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_region();
         expected_peaks.delete();
         gate_sat = '0;
         gate_val = '0;
      end else begin
         // register writes; spare indexes are ignored by the block
         if (csr_wr_en) begin
            case (csr_index)
               ghhp_pkg::CSR_MIN_SAT: gate_sat = csr_wdata;
               ghhp_pkg::CSR_MIN_VAL: gate_val = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_pixel(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      fail_count     <= fails;
      open_count     <= expected_peaks.size();
      result_count   <= results;
      fallback_count <= fallbacks;
   end

endmodule

@@ tb/gated_hue_histogram_peak_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_hue_histogram_peak_tb
// Regression for the gated hue histogram peak finder.
// Drives regions of HSV pixels under a series of gate settings, with random
// gaps on both streams and one long result back-pressure window that fills
// the block; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gated_hue_histogram_peak_tb;

   localparam int STALL_LIMIT  = 4000;   // cycles with no transaction at all
   localparam int LONG_HOLD    = 1200;   // result back-pressure window
   localparam int GAP_CYCLES   = 16;     // quiet time before register writes
   localparam int SCAN_CYCLES  = 200;    // drain plus bin scan after a region
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 140;
   localparam logic [ghhp_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = ghhp_pkg::CSR_IDX_W'(2);
   localparam logic [ghhp_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = ghhp_pkg::CSR_IDX_W'(3);

   typedef logic [ghhp_pkg::PIX_W-1:0] pix_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           csr_wr_en  = 1'b0;
   logic [ghhp_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   pix_type                        csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ghhp_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ghhp_pkg::RSP_W-1:0]     rsp_tdata;
   logic                           rsp_tuser;

   int fail_count;
   int open_count;
   int result_count;
   int fallback_count;

   // stimulus-side copy of the gates, used to shape passing and failing pixels
   pix_type gate_sat = '0;
   pix_type gate_val = '0;

   bit sender_jitter = 1'b0;
   bit sink_jitter   = 1'b0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int pixels_sent   = 0;
   int regions_sent  = 0;
   int gate_settings = 1;
   int quiet_cycles  = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gated_hue_histogram_peak dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   gated_hue_histogram_peak_checker peak_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .open_count     (open_count),
      .result_count   (result_count),
      .fallback_count (fallback_count)
   );

   // Result sink: random stalls, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done < holds_asked) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            rsp_tready <= !(sink_jitter && $urandom_range(99) < 14);
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transaction for %0d cycles", STALL_LIMIT);
         $display("gated_hue_histogram_peak regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One pixel transaction, with a random gap ahead of it
   task automatic drive_pixel(input pix_type hue, input pix_type sat,
                              input pix_type bri, input logic last);
      if (sender_jitter && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bri, sat, hue};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (last) regions_sent++;
   endtask

   // Both gates plus a write to an unused index, only while the block is idle
   task automatic apply_gates(input pix_type sat, input pix_type val);
      csr_wr_en <= 1'b1;
      csr_index <= ghhp_pkg::CSR_MIN_SAT;
      csr_wdata <= sat;
      @(posedge clock);
      csr_index <= ghhp_pkg::CSR_MIN_VAL;
      csr_wdata <= val;
      @(posedge clock);
      csr_index <= $urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= pix_type'($urandom_range(255));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gate_sat = sat;
      gate_val = val;
      gate_settings++;
   endtask

   // Stop offering pixels and hold until every predicted result is back
   task automatic wait_results_done(input int settle);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // One region: exact_pass >= 0 fixes how many leading pixels pass the gate
   task automatic send_region(input int len, input int pass_pct, input int exact_pass);
      pix_type palette[3];
      pix_type hue;
      pix_type sat;
      pix_type bri;
      bit pass;
      int i;
      int how;
      foreach (palette[k]) palette[k] = pix_type'($urandom_range(ghhp_pkg::HUE_BINS - 1));
      for (i = 0; i < len; i++) begin
         pass = (exact_pass >= 0) ? (i < exact_pass) : ($urandom_range(99) < pass_pct);
         if (pass) begin
            // a small palette makes ties between bins common
            hue = $urandom_range(1) ? palette[$urandom_range(2)]
                                    : pix_type'($urandom_range(ghhp_pkg::HUE_BINS - 1));
            sat = pix_type'($urandom_range(255, gate_sat));
            bri = pix_type'($urandom_range(255, gate_val));
         end else begin
            hue = pix_type'($urandom_range(255));
            sat = pix_type'($urandom_range(255));
            bri = pix_type'($urandom_range(255));
            how = $urandom_range(2);
            if (how == 1 && gate_sat != 0) sat = pix_type'($urandom_range(gate_sat - 1));
            else if (how == 2 && gate_val != 0) bri = pix_type'($urandom_range(gate_val - 1));
            else hue = pix_type'($urandom_range(255, ghhp_pkg::HUE_BINS));
         end
         drive_pixel(hue, sat, bri, i == len - 1);
      end
   endtask

   task automatic run_random_phase(input int budget);
      int sent_here;
      int len;
      int pct;
      int exact;
      int pick;
      sent_here = 0;
      while (sent_here < budget) begin
         pick = $urandom_range(99);
         if (pick < 70) len = $urandom_range(24, 1);
         else if (pick < 95) len = $urandom_range(60, 20);
         else len = $urandom_range(200, 100);
         exact = -1;
         case ($urandom_range(5))
            0: pct = 0;
            1: pct = 3;
            2: pct = 10;
            3: pct = 60;
            4: pct = 100;
            default: begin
               // accepted count right at the fallback threshold or one below
               pct   = 0;
               exact = len * ghhp_pkg::FALLBACK_PCT / ghhp_pkg::PCT_DIV -
                       int'($urandom_range(1));
               if (exact < 0) exact = 0;
            end
         endcase
         send_region(len, pct, exact);
         sent_here += len;
      end
   endtask

   initial begin
      int p;
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed regions under the reset gates (both zero)
      drive_pixel(8'd179, 8'd255, 8'd255, 1'b0);          // tie with hue 0: lowest wins
      drive_pixel(8'd0,   8'd0,   8'd0,   1'b1);
      drive_pixel(8'd90,  8'd255, 8'd0,   1'b1);          // single-pixel region
      drive_pixel(8'd180, 8'd255, 8'd255, 1'b0);          // only out-of-range hues
      drive_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      for (i = 0; i < 20; i++) begin                     // nothing passes: fallback
         drive_pixel(pix_type'(ghhp_pkg::HUE_BINS + 3 * i), pix_type'($urandom_range(255)),
                     pix_type'($urandom_range(255)), i == 19);
      end
      wait_results_done(GAP_CYCLES);

      // random regions under a series of gate settings
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_gates(8'd255, 8'd255);
            1: apply_gates(8'd0, 8'd255);
            2: apply_gates(8'd255, 8'd0);
            3: apply_gates(8'd128, 8'd64);
            6: apply_gates(8'd0, 8'd0);
            default: apply_gates(pix_type'($urandom_range(255)), pix_type'($urandom_range(255)));
         endcase
         // one whole phase runs without gaps on either stream
         sender_jitter = (p != 5);
         sink_jitter   = (p != 5);
         if (p == 3) begin
            // two short regions under the hold-off fill the result slot and the scan
            holds_asked++;
            send_region(8, 100, -1);
            send_region(8, 100, -1);
            run_random_phase(PHASE_ITEMS / 2);
            wait_results_done(1);
            run_random_phase(PHASE_ITEMS / 2);
         end else begin
            run_random_phase(PHASE_ITEMS);
         end
         wait_results_done(GAP_CYCLES);
      end
      wait_results_done(SCAN_CYCLES);

      $display("sent %0d pixels in %0d regions across %0d gate settings",
               pixels_sent, regions_sent, gate_settings);
      $display("compared %0d peak results, %0d of them on the fallback hue",
               result_count, fallback_count);
      if (open_count != 0) $error("%0d predicted results never arrived", open_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("gated_hue_histogram_peak regression: pass");
      end else begin
         $display("gated_hue_histogram_peak regression: fail");
      end
      $finish;
   end

endmodule
